// ----- rtl/core/lsgm_pkg.sv -----
// Shared widths and defaults for the least-squares gradient matrix block.
package lsgm_pkg;
    localparam int DEF_MAX_NEIGHBOURS  = 4;
    localparam int DEF_COORD_FRAC_BITS = 24;
    localparam int COORD_W = 32;
    localparam int MAG_W   = 33;
    localparam int PROD_W  = 66;
    localparam int Q_W     = 32;
    localparam int DEF_NUM_W = 82;
endpackage

// ----- rtl/core/least_squares_gradient_matrix.sv -----
// Least-squares gradient weights and 2x2 matrix inverse, one neighbour per request.
// Each request runs three multiplies and five divides before the result loads; a coincident
// point runs only its two squaring multiplies. The last neighbour adds two determinant
// multiplies and three inverse divides (only the multiplies when singular).
// Only one request is in flight; the next is taken the cycle after the result loads.
// Reset (synchronous, active low) clears the accumulators, counter and output valid.
module least_squares_gradient_matrix #(
    parameter int MAX_NEIGHBOURS  = lsgm_pkg::DEF_MAX_NEIGHBOURS,
    parameter int COORD_FRAC_BITS = lsgm_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // center_x, center_y, neighbour_x, neighbour_y
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // neighbour_index, weight_x, weight_y, inv_00, inv_01, inv_10, inv_11, zero pad
    output logic [199:0] o_m_tdata,
    // coincident, singular
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);
    localparam int MW  = lsgm_pkg::MAG_W;
    localparam int PW  = lsgm_pkg::PROD_W;
    localparam int QW  = lsgm_pkg::Q_W;
    localparam int NUM_W = (MW + COORD_FRAC_BITS + 16 > PW + 16) ?
                           (MW + COORD_FRAC_BITS + 16) : (PW + 16);
    localparam int NB_W = ($clog2(MAX_NEIGHBOURS) < 2) ? 2 : $clog2(MAX_NEIGHBOURS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    localparam logic [3:0] OP_MXX  = 4'd0;
    localparam logic [3:0] OP_MYY  = 4'd1;
    localparam logic [3:0] OP_MXY  = 4'd2;
    localparam logic [3:0] OP_WX   = 4'd3;
    localparam logic [3:0] OP_WY   = 4'd4;
    localparam logic [3:0] OP_AXX  = 4'd5;
    localparam logic [3:0] OP_AYY  = 4'd6;
    localparam logic [3:0] OP_AXY  = 4'd7;
    localparam logic [3:0] OP_DET1 = 4'd8;
    localparam logic [3:0] OP_DET2 = 4'd9;
    localparam logic [3:0] OP_INV0 = 4'd10;
    localparam logic [3:0] OP_INV1 = 4'd11;
    localparam logic [3:0] OP_INV3 = 4'd12;

    logic [1:0]      r_state;
    logic [3:0]      r_op;
    logic [MW-1:0]   r_mx, r_my;
    logic            r_sx, r_sy, r_last, r_coin, r_sing;
    logic [PW-1:0]   r_pxx, r_pyy, r_pxy, r_p1, r_dm;
    logic            r_dn;
    logic [QW-1:0]   r_wx, r_wy, r_inv0, r_inv1, r_inv3;
    logic [QW-1:0]   r_acc_xx, r_acc_xy, r_acc_yy;
    logic [NB_W-1:0] r_cnt;
    logic            r_out_valid;
    logic [199:0]    r_tdata;
    logic [1:0]      r_tuser;
    logic            r_tlast;

    logic            accept;
    logic [MW-1:0]   dx, dy;
    logic            is_mul;
    logic            mul_start, div_start, mul_done, div_done;
    logic [MW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   prod;
    logic [NUM_W-1:0] div_num;
    logic [PW-1:0]   div_den;
    logic            div_neg;
    logic [QW-1:0]   quot;
    logic [QW-1:0]   mag_xx, mag_xy, mag_yy;
    logic [PW-1:0]   det;
    logic [PW-1:0]   det_mag;
    logic [3:0]      n_op;
    logic            n_fin;
    logic            fin_load;

    function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1]) begin
            return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        return s[QW-1:0];
    endfunction

    function automatic logic [QW-1:0] mag32(input logic [QW-1:0] v);
        return v[QW-1] ? (~v + 1'b1) : v;
    endfunction

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        dx = {i_s_tdata[95], i_s_tdata[95:64]} - {i_s_tdata[31], i_s_tdata[31:0]};
        dy = {i_s_tdata[127], i_s_tdata[127:96]} - {i_s_tdata[63], i_s_tdata[63:32]};
        mag_xx = mag32(r_acc_xx);
        mag_xy = mag32(r_acc_xy);
        mag_yy = mag32(r_acc_yy);
        det = ((r_acc_xx[QW-1] ^ r_acc_yy[QW-1]) ? (~r_p1 + 1'b1) : r_p1) - prod;
        det_mag = det[PW-1] ? (~det + 1'b1) : det;
    end

    always_comb begin
        is_mul  = 1'b0;
        mul_a   = r_mx;
        mul_b   = r_mx;
        div_num = {{(NUM_W-MW){1'b0}}, r_mx} << (COORD_FRAC_BITS + 16);
        div_den = r_pxx + r_pyy;
        div_neg = r_sx;
        unique case (r_op)
            OP_MXX: begin
                is_mul = 1'b1;
            end
            OP_MYY: begin
                is_mul = 1'b1;
                mul_a  = r_my;
                mul_b  = r_my;
            end
            OP_MXY: begin
                is_mul = 1'b1;
                mul_b  = r_my;
            end
            OP_WX: begin
            end
            OP_WY: begin
                div_num = {{(NUM_W-MW){1'b0}}, r_my} << (COORD_FRAC_BITS + 16);
                div_neg = r_sy;
            end
            OP_AXX: begin
                div_num = {{(NUM_W-PW){1'b0}}, r_pxx} << 16;
                div_neg = 1'b0;
            end
            OP_AYY: begin
                div_num = {{(NUM_W-PW){1'b0}}, r_pyy} << 16;
                div_neg = 1'b0;
            end
            OP_AXY: begin
                div_num = {{(NUM_W-PW){1'b0}}, r_pxy} << 16;
                div_neg = r_sx ^ r_sy;
            end
            OP_DET1: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, mag_xx};
                mul_b  = {1'b0, mag_yy};
            end
            OP_DET2: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, mag_xy};
                mul_b  = {1'b0, mag_xy};
            end
            OP_INV0: begin
                div_num = {{(NUM_W-QW){1'b0}}, mag_yy} << 32;
                div_den = r_dm;
                div_neg = r_acc_yy[QW-1] ^ r_dn;
            end
            OP_INV1: begin
                div_num = {{(NUM_W-QW){1'b0}}, mag_xy} << 32;
                div_den = r_dm;
                div_neg = (~r_acc_xy[QW-1]) ^ r_dn;
            end
            OP_INV3: begin
                div_num = {{(NUM_W-QW){1'b0}}, mag_xx} << 32;
                div_den = r_dm;
                div_neg = r_acc_xx[QW-1] ^ r_dn;
            end
            default: begin
            end
        endcase
    end

    assign mul_start = (r_state == S_LAUNCH) && is_mul;
    assign div_start = (r_state == S_LAUNCH) && !is_mul;

    always_comb begin
        n_op  = r_op;
        n_fin = 1'b0;
        unique case (r_op)
            OP_MXX:  n_op = OP_MYY;
            OP_MYY: begin
                if (r_coin) begin
                    n_op  = OP_DET1;
                    n_fin = !r_last;
                end else begin
                    n_op = OP_MXY;
                end
            end
            OP_MXY:  n_op = OP_WX;
            OP_WX:   n_op = OP_WY;
            OP_WY:   n_op = OP_AXX;
            OP_AXX:  n_op = OP_AYY;
            OP_AYY:  n_op = OP_AXY;
            OP_AXY: begin
                n_op  = OP_DET1;
                n_fin = !r_last;
            end
            OP_DET1: n_op = OP_DET2;
            OP_DET2: begin
                n_op  = OP_INV0;
                n_fin = (det == '0);
            end
            OP_INV0: n_op = OP_INV1;
            OP_INV1: n_op = OP_INV3;
            OP_INV3: n_fin = 1'b1;
            default: n_fin = 1'b1;
        endcase
    end

    assign fin_load = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_MXX;
            r_acc_xx    <= '0;
            r_acc_xy    <= '0;
            r_acc_yy    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !fin_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mx    <= dx[MW-1] ? (~dx + 1'b1) : dx;
                        r_my    <= dy[MW-1] ? (~dy + 1'b1) : dy;
                        r_sx    <= dx[MW-1];
                        r_sy    <= dy[MW-1];
                        r_coin  <= (dx == '0) && (dy == '0);
                        r_last  <= i_s_tlast;
                        r_sing  <= 1'b0;
                        r_wx    <= '0;
                        r_wy    <= '0;
                        r_inv0  <= '0;
                        r_inv1  <= '0;
                        r_inv3  <= '0;
                        r_op    <= OP_MXX;
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_done || div_done) begin
                        unique case (r_op)
                            OP_MXX:  r_pxx <= prod;
                            OP_MYY:  r_pyy <= prod;
                            OP_MXY:  r_pxy <= prod;
                            OP_WX:   r_wx  <= quot;
                            OP_WY:   r_wy  <= quot;
                            OP_AXX:  r_acc_xx <= sat_add(r_acc_xx, quot);
                            OP_AYY:  r_acc_yy <= sat_add(r_acc_yy, quot);
                            OP_AXY:  r_acc_xy <= sat_add(r_acc_xy, quot);
                            OP_DET1: r_p1 <= prod;
                            OP_DET2: begin
                                r_dm   <= det_mag;
                                r_dn   <= det[PW-1];
                                r_sing <= (det == '0);
                            end
                            OP_INV0: r_inv0 <= quot;
                            OP_INV1: r_inv1 <= quot;
                            OP_INV3: r_inv3 <= quot;
                            default: begin
                            end
                        endcase
                        r_op    <= n_op;
                        r_state <= n_fin ? S_FIN : S_LAUNCH;
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_tdata <= {6'd0, r_inv3, r_inv1, r_inv1, r_inv0,
                                    r_wy, r_wx, r_cnt[1:0]};
                        r_tuser <= {r_sing, r_coin};
                        r_tlast <= r_last;
                        r_out_valid <= 1'b1;
                        if (r_last) begin
                            r_acc_xx <= '0;
                            r_acc_xy <= '0;
                            r_acc_yy <= '0;
                            r_cnt    <= '0;
                        end else if (32'(r_cnt) + 1 >= MAX_NEIGHBOURS) begin
                            r_cnt <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lsgm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    lsgm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;
    assign o_m_tlast  = r_tlast;

    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[65:2] == '0))
        else $error("coincident result with nonzero weights");
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[193:66] == '0))
        else $error("singular result with nonzero inverse");
    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (!o_m_tuser[1] && o_m_tdata[193:66] == '0))
        else $error("inverse fields set before last neighbour");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("request taken while one is in progress");
endmodule

// ----- rtl/core/lsgm_mul.sv -----
// Bit-serial shift-add multiplier for unsigned magnitudes.
module lsgm_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lsgm_pkg::MAG_W-1:0]  i_a,
    input  logic [lsgm_pkg::MAG_W-1:0]  i_b,
    output logic                      o_done,
    output logic [lsgm_pkg::PROD_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(lsgm_pkg::MAG_W + 1);

    logic [lsgm_pkg::PROD_W-1:0] r_a;
    logic [lsgm_pkg::MAG_W-1:0]  r_b;
    logic [lsgm_pkg::PROD_W-1:0] r_p;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= {{(lsgm_pkg::PROD_W-lsgm_pkg::MAG_W){1'b0}}, i_a};
                r_b    <= i_b;
                r_p    <= '0;
                r_cnt  <= CNT_W'(lsgm_pkg::MAG_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_p <= r_p + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

// ----- rtl/core/lsgm_div.sv -----
// Bit-serial restoring divider with signed, saturated 32-bit quotient.
module lsgm_div #(
    parameter int NUM_W = lsgm_pkg::DEF_NUM_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [lsgm_pkg::PROD_W-1:0] i_den,
    input  logic                      i_neg,
    output logic                      o_done,
    output logic [lsgm_pkg::Q_W-1:0]  o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int PW    = lsgm_pkg::PROD_W;
    localparam int QW    = lsgm_pkg::Q_W;

    logic [NUM_W-1:0] r_num;
    logic [PW-1:0]    r_den;
    logic [PW-1:0]    r_rem;
    logic [QW:0]      r_q;
    logic             r_over;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [QW-1:0]    r_quot;

    logic [PW:0]   rem_sh;
    logic          qb;
    logic [PW:0]   rem_nx;
    logic [QW:0]   cap;
    logic [QW:0]   qn;
    logic          n_over;
    logic [QW:0]   n_q;
    logic [QW:0]   fmag;
    logic [QW:0]   fval;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        qb     = rem_sh >= {1'b0, r_den};
        rem_nx = qb ? rem_sh - {1'b0, r_den} : rem_sh;
        cap    = r_neg ? {2'b01, {(QW-1){1'b0}}} : {2'b00, {(QW-1){1'b1}}};
        qn     = {r_q[QW-1:0], qb};
        n_over = r_over | (qn > cap);
        n_q    = r_over ? r_q : qn;
        fmag   = n_over ? cap : n_q;
        fval   = r_neg ? (~fmag + 1'b1) : fmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_neg  <= i_neg;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num  <= r_num << 1;
                r_rem  <= rem_nx[PW-1:0];
                r_q    <= n_q;
                r_over <= n_over;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= fval[QW-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- test/least_squares_gradient_matrix_tb.sv -----
// Self-checking testbench for the least-squares gradient weights and matrix inverse block.
`timescale 1ns / 100ps

module least_squares_gradient_matrix_tb;

    localparam int NBR_MAX   = lsgm_pkg::DEF_MAX_NEIGHBOURS;
    localparam int FRAC      = lsgm_pkg::DEF_COORD_FRAC_BITS;
    localparam int RAND_ITEMS = 1200;
    localparam int QUIET_TAIL = 120;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN_CYCLES = 1000;

    typedef struct packed {
        logic [1:0]  idx;
        logic [31:0] wx;
        logic [31:0] wy;
        logic        coin;
        logic        ready;
        logic [31:0] inv00;
        logic [31:0] inv01;
        logic [31:0] inv10;
        logic [31:0] inv11;
        logic        sing;
    } t_grad_result;

    typedef struct {
        logic [31:0]  cx;
        logic [31:0]  cy;
        logic [31:0]  nx;
        logic [31:0]  ny;
        logic         last;
        bit           typed;
        t_grad_result want;
    } t_grad_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // center_x, center_y, neighbour_x, neighbour_y
    logic [127:0] i_s_tdata;
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // neighbour_index, weight_x, weight_y, inv_00, inv_01, inv_10, inv_11, zero pad
    logic [199:0] o_m_tdata;
    // coincident, singular
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    least_squares_gradient_matrix dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_grad_result expected_results[$];
    longint       sum_xx, sum_xy, sum_yy;
    int unsigned  nbr_count;
    int           errors;
    int           items_sent;
    int           cells_closed;
    int           coincident_seen;
    int           singular_seen;
    int           hold_cycles;
    bit           quiet;
    int           idle_count;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic longint div_sat(bit neg, logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        logic [127:0] cap;
        cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        q = num / den;
        if (q > cap) q = cap;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic logic [127:0] magnitude(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic t_grad_result gradient_step(logic [31:0] cx, logic [31:0] cy,
                                                   logic [31:0] nx, logic [31:0] ny,
                                                   logic last);
        t_grad_result r;
        longint       dx, dy, det;
        logic [127:0] mx, my, d2, dm;
        bit           dn;
        r = '0;
        dx = longint'(signed'(nx)) - longint'(signed'(cx));
        dy = longint'(signed'(ny)) - longint'(signed'(cy));
        mx = magnitude(dx);
        my = magnitude(dy);
        d2 = mx * mx + my * my;
        r.idx = nbr_count[1:0];
        if (d2 == 0) begin
            r.coin = 1'b1;
        end else begin
            r.wx = 32'(div_sat(dx < 0, mx << (FRAC + 16), d2));
            r.wy = 32'(div_sat(dy < 0, my << (FRAC + 16), d2));
            sum_xx = sat32(sum_xx + div_sat(1'b0, (mx * mx) << 16, d2));
            sum_yy = sat32(sum_yy + div_sat(1'b0, (my * my) << 16, d2));
            sum_xy = sat32(sum_xy + div_sat((dx < 0) != (dy < 0), (mx * my) << 16, d2));
        end
        if (last) begin
            r.ready = 1'b1;
            det = sum_xx * sum_yy - sum_xy * sum_xy;
            if (det == 0) begin
                r.sing = 1'b1;
            end else begin
                dm = magnitude(det);
                dn = det < 0;
                r.inv00 = 32'(div_sat((sum_yy < 0) != dn, magnitude(sum_yy) << 32, dm));
                r.inv01 = 32'(div_sat((sum_xy >= 0) != dn, magnitude(sum_xy) << 32, dm));
                r.inv10 = r.inv01;
                r.inv11 = 32'(div_sat((sum_xx < 0) != dn, magnitude(sum_xx) << 32, dm));
            end
            sum_xx = 0;
            sum_xy = 0;
            sum_yy = 0;
            nbr_count = 0;
        end else begin
            nbr_count = (nbr_count + 1 >= NBR_MAX) ? 0 : nbr_count + 1;
        end
        return r;
    endfunction

    task automatic send_neighbour(t_grad_row row);
        t_grad_result r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {row.ny, row.nx, row.cy, row.cx};
        i_s_tlast  <= row.last;
        do @(posedge i_clk); while (!o_s_tready);
        r = gradient_step(row.cx, row.cy, row.nx, row.ny, row.last);
        expected_results = {expected_results, (row.typed ? row.want : r)};
        items_sent++;
    endtask

    function automatic logic [31:0] random_offset();
        return 32'(signed'($urandom()) >>> $urandom_range(0, 31));
    endfunction

    // Reference point at 0, one unit step along each axis.
    localparam logic [31:0] ONE = 32'h0100_0000;
    localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [31:0] MINC = 32'h8000_0000;

    t_grad_row directed[$];

    task automatic add_row(logic [31:0] cx, logic [31:0] cy, logic [31:0] nx,
                           logic [31:0] ny, logic last, bit typed, t_grad_result want);
        t_grad_row row;
        row.cx = cx;
        row.cy = cy;
        row.nx = nx;
        row.ny = ny;
        row.last = last;
        row.typed = typed;
        row.want = want;
        directed = {directed, row};
    endtask

    initial begin
        t_grad_result w;
        t_grad_row    row;
        int           cell_len;
        logic [31:0]  cx, cy;
        bit           held;
        bit           drained;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        sum_xx = 0;
        sum_xy = 0;
        sum_yy = 0;
        nbr_count = 0;
        errors = 0;
        items_sent = 0;
        cells_closed = 0;
        coincident_seen = 0;
        singular_seen = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        held = 1'b0;
        drained = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coincident lone point right after reset: zero weights, singular inverse
        w = '0;
        w.coin = 1'b1;
        w.ready = 1'b1;
        w.sing = 1'b1;
        add_row('0, '0, '0, '0, 1'b1, 1'b1, w);
        // unit steps along x then y give identity weights and identity inverse
        w = '0;
        w.wx = 32'h0001_0000;
        add_row('0, '0, ONE, '0, 1'b0, 1'b1, w);
        w = '0;
        w.idx = 2'd1;
        w.wy = 32'h0001_0000;
        w.ready = 1'b1;
        w.inv00 = 32'h0001_0000;
        w.inv11 = 32'h0001_0000;
        add_row('0, '0, '0, ONE, 1'b1, 1'b1, w);
        w = '0;
        // extremes of the coordinate range
        add_row(MINC, MINC, MAXC, MAXC, 1'b0, 1'b0, w);
        add_row(MAXC, MAXC, MINC, MINC, 1'b0, 1'b0, w);
        add_row(MAXC, MINC, MINC, MAXC, 1'b1, 1'b0, w);
        // tiny offsets saturate the weights
        add_row('0, '0, 32'd1, '0, 1'b0, 1'b0, w);
        add_row('0, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, w);
        add_row(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0, w);
        // collinear neighbours leave a singular matrix
        add_row('0, '0, ONE, '0, 1'b0, 1'b0, w);
        add_row('0, '0, -ONE, '0, 1'b0, 1'b0, w);
        add_row('0, '0, 32'h0300_0000, '0, 1'b1, 1'b0, w);
        // no last mark until the sixth row: the counter wraps while the sums keep growing
        add_row('0, '0, ONE, ONE, 1'b0, 1'b0, w);
        add_row('0, '0, -ONE, ONE, 1'b0, 1'b0, w);
        add_row('0, '0, ONE, '0, 1'b0, 1'b0, w);
        add_row('0, '0, '0, -ONE, 1'b0, 1'b0, w);
        add_row('0, '0, 32'h0080_0000, 32'h0040_0000, 1'b0, 1'b0, w);
        add_row(32'hFF00_0000, 32'h0100_0000, '0, '0, 1'b1, 1'b0, w);
        // coincident point inside a cell
        add_row(ONE, ONE, ONE, ONE, 1'b0, 1'b0, w);
        add_row(ONE, ONE, '0, ONE, 1'b0, 1'b0, w);
        add_row(ONE, ONE, ONE, '0, 1'b1, 1'b0, w);

        foreach (directed[k]) send_neighbour(directed[k]);

        while (items_sent < directed.size() + RAND_ITEMS) begin
            quiet = items_sent > directed.size() + RAND_ITEMS - QUIET_TAIL;
            if (!held && items_sent >= directed.size() + 300) begin
                hold_cycles = LONG_HOLD;
                held = 1'b1;
            end
            if (!drained && items_sent >= directed.size() + 600) begin
                i_s_tvalid <= 1'b0;
                while (expected_results.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
                drained = 1'b1;
            end
            cell_len = ($urandom_range(0, 29) == 0) ? 6 : $urandom_range(1, 5);
            cx = $urandom();
            cy = $urandom();
            for (int n = 0; n < cell_len; n++) begin
                row.cx = cx;
                row.cy = cy;
                case ($urandom_range(0, 19))
                    0: begin
                        row.nx = cx;
                        row.ny = cy;
                    end
                    1, 2: begin
                        row.cx = $urandom();
                        row.cy = $urandom();
                        row.nx = $urandom();
                        row.ny = $urandom();
                    end
                    default: begin
                        row.nx = cx + random_offset();
                        row.ny = cy + random_offset();
                    end
                endcase
                row.last = (n == cell_len - 1) && cell_len != 6;
                row.typed = 1'b0;
                row.want = '0;
                send_neighbour(row);
            end
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("results still outstanding: %0d", expected_results.size());
            errors++;
        end
        $display("Sent %0d neighbour requests; %0d cells inverted, %0d singular,",
                 items_sent, cells_closed, singular_seen);
        $display("%0d coincident points, including a long output stall and a full drain.",
                 coincident_seen);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int gap;
        i_m_tready = 1'b0;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else if (quiet) begin
                i_m_tready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 13) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grad_result want;
        t_grad_result got;
        if (o_m_tvalid && i_m_tready && i_rst_n) begin
            got.idx   = o_m_tdata[1:0];
            got.wx    = o_m_tdata[33:2];
            got.wy    = o_m_tdata[65:34];
            got.inv00 = o_m_tdata[97:66];
            got.inv01 = o_m_tdata[129:98];
            got.inv10 = o_m_tdata[161:130];
            got.inv11 = o_m_tdata[193:162];
            got.coin  = o_m_tuser[0];
            got.sing  = o_m_tuser[1];
            got.ready = o_m_tlast;
            if (got.coin) coincident_seen++;
            if (got.sing) singular_seen++;
            if (got.ready) cells_closed++;
            if (expected_results.size() == 0) begin
                $error("unexpected result with no request pending");
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.idx !== want.idx) begin
                    $error("neighbour_index expected %0d got %0d", want.idx, got.idx);
                    errors++;
                end
                if (got.wx !== want.wx) begin
                    $error("weight_x expected %h got %h", want.wx, got.wx);
                    errors++;
                end
                if (got.wy !== want.wy) begin
                    $error("weight_y expected %h got %h", want.wy, got.wy);
                    errors++;
                end
                if (got.coin !== want.coin) begin
                    $error("coincident expected %b got %b", want.coin, got.coin);
                    errors++;
                end
                if (got.ready !== want.ready) begin
                    $error("inverse_ready expected %b got %b", want.ready, got.ready);
                    errors++;
                end
                if (got.inv00 !== want.inv00) begin
                    $error("inv_00 expected %h got %h", want.inv00, got.inv00);
                    errors++;
                end
                if (got.inv01 !== want.inv01) begin
                    $error("inv_01 expected %h got %h", want.inv01, got.inv01);
                    errors++;
                end
                if (got.inv10 !== want.inv10) begin
                    $error("inv_10 expected %h got %h", want.inv10, got.inv10);
                    errors++;
                end
                if (got.inv11 !== want.inv11) begin
                    $error("inv_11 expected %h got %h", want.inv11, got.inv11);
                    errors++;
                end
                if (got.sing !== want.sing) begin
                    $error("singular expected %b got %b", want.sing, got.sing);
                    errors++;
                end
            end
        end
    end

    initial idle_count = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

endmodule
